/* rtl/core/imhq_pkg.sv */
package imhq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_INCR    = 3'd4;
    localparam logic [2:0] ST_DUP     = 3'd5;

    localparam int VID_W = 8;
    localparam int NUM_VERTS = 256;
    localparam int KEY_W = 32;

    // datapath register write selects
    typedef enum logic [2:0] {
        LD_NONE,
        LD_A,       // latch read port data into entry A
        LD_B,       // latch read port data into entry B
        LD_C,       // latch read port data into entry C
        LD_CB       // copy entry C into entry B
    } load_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       latch_in;     // capture start payload
        logic [2:0] rd_sel;       // heap read address select
        load_sel_t  load;
        logic [2:0] wr_sel;       // heap write select
        logic [2:0] pw_sel;       // position map write select
        logic [2:0] cur_sel;      // cursor update select
        logic       cnt_inc;
        logic       cnt_dec;
        logic       keep_root;    // capture root as result
        logic [2:0] st;
        logic       done;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       present;      // position map entry nonzero
        logic       pos_valid;    // present and within count
        logic       full;
        logic       empty;
        logic       cnt_one;
        logic       at_root;
        logic       a_lt_b;       // key A < key B
        logic       c_lt_b;       // key C < key B
        logic       has_left;
        logic       has_right;
        logic       b_lt_in;      // held key < new key
    } sts_t;

    // read address selects
    localparam logic [2:0] RA_CUR    = 3'd0;
    localparam logic [2:0] RA_PARENT = 3'd1;
    localparam logic [2:0] RA_LEFT   = 3'd2;
    localparam logic [2:0] RA_RIGHT  = 3'd3;
    localparam logic [2:0] RA_LAST   = 3'd4;
    localparam logic [2:0] RA_ROOT   = 3'd5;

    // heap write selects
    localparam logic [2:0] WR_NONE     = 3'd0;
    localparam logic [2:0] WR_NEW_CNT  = 3'd1; // input entry at count+1
    localparam logic [2:0] WR_KEY_CUR  = 3'd2; // new key at cursor
    localparam logic [2:0] WR_A_AT_B   = 3'd3; // A to B's slot
    localparam logic [2:0] WR_B_AT_A   = 3'd4; // B to A's slot
    localparam logic [2:0] WR_C_ROOT   = 3'd5; // last entry to root

    // position map write selects
    localparam logic [2:0] PW_NONE  = 3'd0;
    localparam logic [2:0] PW_A     = 3'd1; // vertex A -> slot of B
    localparam logic [2:0] PW_B     = 3'd2; // vertex B -> slot of A
    localparam logic [2:0] PW_NEW   = 3'd3; // input vertex -> count+1
    localparam logic [2:0] PW_ROOT  = 3'd4; // vertex C -> slot 1
    localparam logic [2:0] PW_CLR   = 3'd5; // removed vertex -> absent

    localparam logic [2:0] CUR_HOLD  = 3'd0;
    localparam logic [2:0] CUR_NEW   = 3'd1; // count + 1
    localparam logic [2:0] CUR_POS   = 3'd2; // position map value
    localparam logic [2:0] CUR_ONE   = 3'd3;
    localparam logic [2:0] CUR_B     = 3'd4; // slot of entry B

endpackage

/* rtl/core/imhq_datapath.sv */
module imhq_datapath
    import imhq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              opcode,
    input  logic [VID_W-1:0]        vertex_id,
    input  logic signed [KEY_W-1:0] key_in,
    input  ctl_t                    ctl,
    output sts_t                    sts,
    output logic [VID_W-1:0]        res_vertex,
    output logic signed [KEY_W-1:0] res_key,
    output logic [$clog2(CAPACITY + 1)-1:0] count
);

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int CNT_W = SLOT_W;

    // heap slot memories, slots 1..CAPACITY
    logic [KEY_W-1:0] key_mem [0:CAPACITY];
    logic [VID_W-1:0] vid_mem [0:CAPACITY];
    // position map, cleared by valid bits
    logic [SLOT_W-1:0] pos_mem [0:NUM_VERTS-1];
    logic [NUM_VERTS-1:0] pos_vld_reg;

    logic [1:0]              op_reg;
    logic [VID_W-1:0]        in_vid_reg;
    logic signed [KEY_W-1:0] in_key_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SLOT_W-1:0]       cur_reg;
    logic [SLOT_W-1:0]       pos_reg;
    logic                    pos_hit_reg;
    logic [KEY_W-1:0]        rd_key_reg;
    logic [VID_W-1:0]        rd_vid_reg;
    logic [SLOT_W-1:0]       a_slot_reg, b_slot_reg, c_slot_reg;
    logic signed [KEY_W-1:0] a_key_reg, b_key_reg, c_key_reg;
    logic [VID_W-1:0]        a_vid_reg, b_vid_reg, c_vid_reg;
    logic [VID_W-1:0]        res_vid_reg;
    logic signed [KEY_W-1:0] res_key_reg;
    logic [SLOT_W-1:0]       rd_addr, rd_addr_reg;
    logic [SLOT_W-1:0]       new_slot;
    logic [SLOT_W:0]         left_w, right_w;

    assign left_w   = {cur_reg, 1'b0};
    assign right_w  = {cur_reg, 1'b1};
    assign new_slot = cnt_reg + SLOT_W'(1);

    always_comb
    begin
        unique case (ctl.rd_sel)
            RA_PARENT: rd_addr = cur_reg >> 1;
            RA_LEFT:   rd_addr = left_w[SLOT_W-1:0];
            RA_RIGHT:  rd_addr = right_w[SLOT_W-1:0];
            RA_LAST:   rd_addr = cnt_reg;
            RA_ROOT:   rd_addr = SLOT_W'(1);
            default:   rd_addr = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_vid_reg  <= vid_mem[rd_addr];
        rd_addr_reg <= rd_addr;
        pos_reg     <= pos_mem[in_vid_reg];
        unique case (ctl.wr_sel)
            WR_NEW_CNT:
            begin
                key_mem[new_slot] <= in_key_reg;
                vid_mem[new_slot] <= in_vid_reg;
            end
            WR_KEY_CUR: key_mem[cur_reg] <= in_key_reg;
            WR_A_AT_B:
            begin
                key_mem[b_slot_reg] <= a_key_reg;
                vid_mem[b_slot_reg] <= a_vid_reg;
            end
            WR_B_AT_A:
            begin
                key_mem[a_slot_reg] <= b_key_reg;
                vid_mem[a_slot_reg] <= b_vid_reg;
            end
            WR_C_ROOT:
            begin
                key_mem[1] <= c_key_reg;
                vid_mem[1] <= c_vid_reg;
            end
            default: ;
        endcase
        unique case (ctl.pw_sel)
            PW_A:    pos_mem[a_vid_reg] <= b_slot_reg;
            PW_B:    pos_mem[b_vid_reg] <= a_slot_reg;
            PW_NEW:  pos_mem[in_vid_reg] <= new_slot;
            PW_ROOT: pos_mem[c_vid_reg] <= SLOT_W'(1);
            default: ;
        endcase
        if (ctl.latch_in)
        begin
            in_vid_reg <= vertex_id;
            in_key_reg <= key_in;
        end
        unique case (ctl.load)
            LD_A:
            begin
                a_key_reg <= rd_key_reg; a_vid_reg <= rd_vid_reg; a_slot_reg <= rd_addr_reg;
            end
            LD_B:
            begin
                b_key_reg <= rd_key_reg; b_vid_reg <= rd_vid_reg; b_slot_reg <= rd_addr_reg;
            end
            LD_C:
            begin
                c_key_reg <= rd_key_reg; c_vid_reg <= rd_vid_reg; c_slot_reg <= rd_addr_reg;
            end
            LD_CB:
            begin
                b_key_reg <= c_key_reg; b_vid_reg <= c_vid_reg; b_slot_reg <= c_slot_reg;
            end
            default: ;
        endcase
        if (ctl.keep_root)
        begin
            res_vid_reg <= rd_vid_reg;
            res_key_reg <= rd_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= 2'd0;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            pos_vld_reg <= '0;
            pos_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.latch_in)
                op_reg <= opcode;
            pos_hit_reg <= pos_vld_reg[in_vid_reg];
            unique case (ctl.pw_sel)
                PW_NEW:  pos_vld_reg[in_vid_reg] <= 1'b1;
                PW_ROOT: pos_vld_reg[c_vid_reg] <= 1'b1;
                PW_CLR:  pos_vld_reg[res_vid_reg] <= 1'b0;
                default: ;
            endcase
            if (ctl.cnt_inc)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (ctl.cnt_dec)
                cnt_reg <= cnt_reg - CNT_W'(1);
            unique case (ctl.cur_sel)
                CUR_NEW: cur_reg <= new_slot;
                CUR_POS: cur_reg <= pos_reg;
                CUR_ONE: cur_reg <= SLOT_W'(1);
                CUR_B:   cur_reg <= b_slot_reg;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.present   = pos_hit_reg && pos_reg != '0;
        sts.pos_valid = pos_hit_reg && pos_reg != '0 && pos_reg <= cnt_reg;
        sts.full      = cnt_reg >= CNT_W'(CAPACITY);
        sts.empty     = cnt_reg == '0;
        sts.cnt_one   = cnt_reg == CNT_W'(1);
        sts.at_root   = cur_reg == SLOT_W'(1);
        sts.a_lt_b    = a_key_reg < b_key_reg;
        sts.c_lt_b    = c_key_reg < b_key_reg;
        sts.has_left  = left_w <= {1'b0, cnt_reg};
        sts.has_right = right_w <= {1'b0, cnt_reg};
        sts.b_lt_in   = b_key_reg < in_key_reg;
    end

    assign res_vertex = res_vid_reg;
    assign res_key    = res_key_reg;
    assign count      = cnt_reg;

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(CAPACITY);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("count above capacity");

    property p_inc_not_full;
        @(posedge clk) disable iff (!rst_n) ctl.cnt_inc |-> !sts.full;
    endproperty
    a_inc_not_full: assert property (p_inc_not_full) else $error("insert into full heap");

    property p_dec_not_empty;
        @(posedge clk) disable iff (!rst_n) ctl.cnt_dec |-> !sts.empty;
    endproperty
    a_dec_not_empty: assert property (p_dec_not_empty) else $error("remove from empty heap");

endmodule

/* rtl/core/imhq_ctrl.sv */
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_POS     = 5'd1;  // position map read in flight
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_UPDRD   = 5'd3;
    localparam logic [4:0] S_UPDLB   = 5'd4;
    localparam logic [4:0] S_UPDCK   = 5'd5;
    localparam logic [4:0] S_UPRD    = 5'd6;  // read cursor
    localparam logic [4:0] S_UPRD2   = 5'd7;  // read parent
    localparam logic [4:0] S_UPLB    = 5'd8;
    localparam logic [4:0] S_UPCMP   = 5'd9;
    localparam logic [4:0] S_UPSW    = 5'd10;
    localparam logic [4:0] S_SW2     = 5'd11; // second swap write
    localparam logic [4:0] S_RMRD    = 5'd12; // read root
    localparam logic [4:0] S_RMLAST  = 5'd13; // read last
    localparam logic [4:0] S_CLR     = 5'd14;
    localparam logic [4:0] S_RMMOVE  = 5'd15;
    localparam logic [4:0] S_DNRD    = 5'd16; // read cursor
    localparam logic [4:0] S_DNRL    = 5'd17; // read left
    localparam logic [4:0] S_DNRR    = 5'd18; // read right
    localparam logic [4:0] S_DNLC    = 5'd19;
    localparam logic [4:0] S_DNCMP   = 5'd20;
    localparam logic [4:0] S_DNCMP2  = 5'd21;
    localparam logic [4:0] S_DONE    = 5'd22;

    logic [4:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       dn_reg, dn_next;  // swap belongs to sift-down

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            dn_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            dn_reg    <= dn_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        ctl = '0;
        ctl.load = LD_NONE;
        ctl.st = st_reg;
        state_next = state_reg;
        st_next = st_reg;
        dn_next = dn_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    st_next = ST_OK;
                    dn_next = 1'b0;
                    state_next = S_POS;
                end
            S_POS: state_next = S_DISP;
            S_DISP:
                case (sts.op)
                    OP_INSERT:
                        if (sts.present)
                        begin
                            st_next = ST_DUP; state_next = S_DONE;
                        end
                        else if (sts.full)
                        begin
                            st_next = ST_FULL; state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.wr_sel = WR_NEW_CNT;
                            ctl.pw_sel = PW_NEW;
                            ctl.cur_sel = CUR_NEW;
                            ctl.cnt_inc = 1'b1;
                            state_next = S_UPRD;
                        end
                    OP_UPDATE:
                        if (!sts.pos_valid)
                        begin
                            st_next = ST_ABSENT; state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cur_sel = CUR_POS;
                            state_next = S_UPDRD;
                        end
                    OP_REMOVE:
                        if (sts.empty)
                        begin
                            st_next = ST_EMPTY; state_next = S_DONE;
                        end
                        else
                            state_next = S_RMRD;
                    default: state_next = S_DONE;
                endcase
            // update: check held key
            S_UPDRD:
            begin
                ctl.rd_sel = RA_CUR; state_next = S_UPDLB;
            end
            S_UPDLB:
            begin
                ctl.load = LD_B; state_next = S_UPDCK;
            end
            S_UPDCK:
                if (sts.b_lt_in)
                begin
                    st_next = ST_INCR; state_next = S_DONE;
                end
                else
                begin
                    ctl.wr_sel = WR_KEY_CUR; state_next = S_UPRD;
                end
            // sift-up: A = cursor entry, B = parent entry
            S_UPRD:
                if (sts.at_root)
                    state_next = S_DONE;
                else
                begin
                    ctl.rd_sel = RA_CUR; state_next = S_UPRD2;
                end
            S_UPRD2:
            begin
                ctl.rd_sel = RA_PARENT; ctl.load = LD_A; state_next = S_UPLB;
            end
            S_UPLB:
            begin
                ctl.load = LD_B; state_next = S_UPCMP;
            end
            S_UPCMP:
                if (sts.a_lt_b)
                    state_next = S_UPSW;
                else
                    state_next = S_DONE;
            // swap A and B slots; cursor follows A into B's slot
            S_UPSW:
            begin
                ctl.wr_sel = WR_A_AT_B;
                ctl.pw_sel = PW_A;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                ctl.wr_sel = WR_B_AT_A;
                ctl.pw_sel = PW_B;
                ctl.cur_sel = CUR_B;
                state_next = dn_reg ? S_DNRD : S_UPRD;
            end
            // remove-min
            S_RMRD:
            begin
                ctl.rd_sel = RA_ROOT; state_next = S_RMLAST;
            end
            S_RMLAST:
            begin
                ctl.keep_root = 1'b1; ctl.rd_sel = RA_LAST; state_next = S_CLR;
            end
            S_CLR:
            begin
                ctl.load = LD_C; ctl.pw_sel = PW_CLR; state_next = S_RMMOVE;
            end
            S_RMMOVE:
            begin
                ctl.cnt_dec = 1'b1;
                ctl.cur_sel = CUR_ONE;
                if (!sts.cnt_one)
                begin
                    ctl.wr_sel = WR_C_ROOT;
                    ctl.pw_sel = PW_ROOT;
                    dn_next = 1'b1;
                    state_next = S_DNRD;
                end
                else
                    state_next = S_DONE;
            end
            // sift-down: A = cursor entry, B = left then chosen child, C = right child
            S_DNRD:
                if (!sts.has_left)
                    state_next = S_DONE;
                else
                begin
                    ctl.rd_sel = RA_CUR; state_next = S_DNRL;
                end
            S_DNRL:
            begin
                ctl.rd_sel = RA_LEFT; ctl.load = LD_A; state_next = S_DNRR;
            end
            S_DNRR:
            begin
                ctl.load = LD_B;
                if (sts.has_right)
                begin
                    ctl.rd_sel = RA_RIGHT; state_next = S_DNLC;
                end
                else
                    state_next = S_DNCMP;
            end
            S_DNLC:
            begin
                ctl.load = LD_C; state_next = S_DNCMP;
            end
            S_DNCMP:
                // take right child only when strictly smaller than left
                if (sts.has_right && sts.c_lt_b)
                begin
                    ctl.load = LD_CB; state_next = S_DNCMP2;
                end
                else if (!sts.a_lt_b)
                    state_next = S_UPSW;
                else
                    state_next = S_DONE;
            S_DNCMP2:
                if (!sts.a_lt_b)
                    state_next = S_UPSW;
                else
                    state_next = S_DONE;
            S_DONE:
            begin
                ctl.done = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    property p_busy_after_start;
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
    endproperty
    a_busy_after_start: assert property (p_busy_after_start) else $error("start not taken");

    property p_done_from_busy;
        @(posedge clk) disable iff (!rst_n) ctl.done |-> busy;
    endproperty
    a_done_from_busy: assert property (p_done_from_busy) else $error("done while idle");

    property p_idle_after_done;
        @(posedge clk) disable iff (!rst_n) ctl.done |=> !busy;
    endproperty
    a_idle_after_done: assert property (p_idle_after_done) else $error("stuck after done");

endmodule

/* rtl/core/indexed_min_heap_queue.sv */
// Channel  | Ports                                   | Handshake
// command  | opcode, vertex_id, key_in               | start && !busy
// result   | out_vertex, out_key, status, occupancy  | done strobe, one cycle
// One item at a time; busy is high from the cycle after acceptance through done.
// Sift-up and sift-down handle each level with a registered single-port slot read,
// a compare and two swap writes.
// rst_n clears the entry count and the position map valid bits at once.
// Results are strobed for one cycle; the receiver cannot stall them.
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic [VID_W-1:0]        vertex_id,
    input  logic signed [KEY_W-1:0] key_in,
    output logic                    done,
    output logic [VID_W-1:0]        out_vertex,
    output logic signed [KEY_W-1:0] out_key,
    output logic [2:0]              status,
    output logic [8:0]              occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ctl_t ctl;
    sts_t sts;
    logic [VID_W-1:0]        res_vertex;
    logic signed [KEY_W-1:0] res_key;
    logic [CNT_W-1:0]        count;
    logic [VID_W-1:0]        in_vid_reg;
    logic                    rm_ok;

    imhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    imhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .vertex_id  (vertex_id),
        .key_in     (key_in),
        .ctl        (ctl),
        .sts        (sts),
        .res_vertex (res_vertex),
        .res_key    (res_key),
        .count      (count)
    );

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_vid_reg <= vertex_id;
    end

    assign rm_ok = sts.op == OP_REMOVE && ctl.st == ST_OK;

    assign done       = ctl.done;
    assign out_vertex = rm_ok ? res_vertex : in_vid_reg;
    assign out_key    = rm_ok ? res_key : '0;
    assign status     = ctl.st;
    assign occupancy  = 9'(count);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import imhq_pkg::*;

    localparam int HEAP_CAP = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [VID_W-1:0]  vid;
        logic [KEY_W-1:0]  key;
        logic              hold;   // wait for all results before sending
    } cmd_t;

    typedef struct packed {
        logic [VID_W-1:0]  vid;
        logic [KEY_W-1:0]  key;
        logic [2:0]        st;
        logic [8:0]        occ;
    } res_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              opcode;
    logic [VID_W-1:0]        vertex_id;
    logic signed [KEY_W-1:0] key_in;
    logic                    done;
    logic [VID_W-1:0]        out_vertex;
    logic signed [KEY_W-1:0] out_key;
    logic [2:0]              status;
    logic [8:0]              occupancy;

    indexed_min_heap_queue #(.CAPACITY(HEAP_CAP)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .vertex_id(vertex_id), .key_in(key_in),
        .done(done), .out_vertex(out_vertex), .out_key(out_key),
        .status(status), .occupancy(occupancy)
    );

    // predictor state
    logic signed [KEY_W-1:0] heap_key [1:HEAP_CAP];
    logic [VID_W-1:0]        heap_vid [1:HEAP_CAP];
    int unsigned             slot_of [NUM_VERTS] = '{default: 0};
    int unsigned             heap_cnt = 0;

    cmd_t pending_cmds[$];
    res_t expected_res[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   gap;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void heap_swap(int unsigned i, int unsigned j);
        logic signed [KEY_W-1:0] k;
        logic [VID_W-1:0]        v;
        k = heap_key[i]; v = heap_vid[i];
        heap_key[i] = heap_key[j]; heap_vid[i] = heap_vid[j];
        heap_key[j] = k; heap_vid[j] = v;
        slot_of[heap_vid[i]] = i;
        slot_of[heap_vid[j]] = j;
    endfunction

    function automatic void bubble_up(int unsigned p);
        while (p > 1 && heap_key[p] < heap_key[p / 2])
        begin
            heap_swap(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down();
        int unsigned p;
        int unsigned c;
        p = 1;
        while (2 * p <= heap_cnt)
        begin
            c = 2 * p;
            if (c + 1 <= heap_cnt && heap_key[c + 1] < heap_key[c])
                c = c + 1;
            if (!(heap_key[p] < heap_key[c]))
            begin
                heap_swap(p, c);
                p = c;
            end
            else
                break;
        end
    endfunction

    function automatic res_t heap_apply(cmd_t c);
        res_t r;
        int unsigned p;
        r.vid = c.vid; r.key = '0; r.st = ST_OK;
        case (c.op)
            OP_INSERT:
            begin
                if (slot_of[c.vid] != 0) r.st = ST_DUP;
                else if (heap_cnt >= HEAP_CAP) r.st = ST_FULL;
                else
                begin
                    heap_cnt++;
                    heap_key[heap_cnt] = c.key;
                    heap_vid[heap_cnt] = c.vid;
                    slot_of[c.vid] = heap_cnt;
                    bubble_up(heap_cnt);
                end
            end
            OP_UPDATE:
            begin
                p = slot_of[c.vid];
                if (p == 0 || p > heap_cnt) r.st = ST_ABSENT;
                else if (heap_key[p] < $signed(c.key)) r.st = ST_INCR;
                else
                begin
                    heap_key[p] = c.key;
                    bubble_up(p);
                end
            end
            OP_REMOVE:
            begin
                if (heap_cnt == 0) r.st = ST_EMPTY;
                else
                begin
                    r.vid = heap_vid[1];
                    r.key = heap_key[1];
                    slot_of[heap_vid[1]] = 0;
                    if (heap_cnt > 1)
                    begin
                        heap_key[1] = heap_key[heap_cnt];
                        heap_vid[1] = heap_vid[heap_cnt];
                        slot_of[heap_vid[1]] = 1;
                    end
                    heap_cnt--;
                    bubble_down();
                end
            end
            default: ;
        endcase
        r.occ = heap_cnt[8:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= '0; vertex_id <= '0; key_in <= '0;
            gap <= 0;
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                : $urandom_range(0, 2);
        end
        else if (!start)
        begin
            if (gap > 0) gap <= gap - 1;
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold && expected_res.size() > 0))
            begin
                c = pending_cmds.pop_front();
                expected_res.push_back(heap_apply(c));
                start <= 1'b1;
                opcode <= c.op; vertex_id <= c.vid; key_in <= c.key;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end
            else
            begin
                e = expected_res.pop_front();
                if (out_vertex !== e.vid || out_key !== e.key ||
                    status !== e.st || occupancy !== e.occ)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp v=%0d k=%0d st=%0d occ=%0d,",
                                  " got v=%0d k=%0d st=%0d occ=%0d"},
                                 $time, e.vid, $signed(e.key), e.st, e.occ,
                                 out_vertex, out_key, status, occupancy);
                end
            end
        end
    end

    task automatic add_cmd(logic [1:0] op, logic [VID_W-1:0] v, logic [KEY_W-1:0] k,
                           logic hold = 1'b0);
        cmd_t c;
        c.op = op; c.vid = v; c.key = k; c.hold = hold;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;   // many ties
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n;
        int sel;
        logic [VID_W-1:0] v;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty remove, absent update, extremes, dup, increase, opcode 3
        add_cmd(OP_REMOVE, 8'hFF, 32'h0);
        add_cmd(OP_UPDATE, 8'h00, 32'h0);
        add_cmd(OP_INSERT, 8'h00, 32'h7FFF_FFFF);
        add_cmd(OP_INSERT, 8'hFF, 32'h8000_0000);
        add_cmd(OP_INSERT, 8'h55, 32'h0);
        add_cmd(OP_INSERT, 8'hAA, 32'h0);
        add_cmd(OP_INSERT, 8'h00, 32'h1);
        add_cmd(OP_UPDATE, 8'h55, 32'h5);
        add_cmd(OP_UPDATE, 8'h55, 32'h0);
        add_cmd(OP_UPDATE, 8'h00, 32'hFFFF_FFFF);
        add_cmd(OP_UNUSED, 8'h12, 32'hDEAD_BEEF);
        repeat (6) add_cmd(OP_REMOVE, 8'h00, 32'h0);

        // fill to capacity, then a duplicate insert and a decrease-key on the full heap, then drain
        for (int i = 0; i < HEAP_CAP; i++) add_cmd(OP_INSERT, i[7:0], rand_key());
        add_cmd(OP_INSERT, 8'h10, 32'h0, 1'b1);
        add_cmd(OP_UPDATE, 8'h80, 32'h8000_0000);
        for (int i = 0; i < HEAP_CAP + 1; i++)
            add_cmd(OP_REMOVE, VID_W'($urandom), 32'h0);

        // random, biased to keep a mid-sized heap with frequent decrease-keys
        n = 0;
        while (n < 970)
        begin
            sel = $urandom_range(0, 99);
            v = (n % 400 < 200) ? VID_W'($urandom_range(0, 31)) : VID_W'($urandom);
            if (sel < 40) add_cmd(OP_INSERT, v, rand_key(), (n % 300) == 299);
            else if (sel < 65)
                add_cmd(OP_UPDATE, v, ($urandom_range(0, 3) == 0) ?
                        rand_key() : 32'h8000_0000 + $urandom_range(0, 1 << 30));
            else if (sel < 97) add_cmd(OP_REMOVE, VID_W'($urandom), $urandom);
            else add_cmd(OP_UNUSED, VID_W'($urandom), $urandom);
            n++;
        end

        while (pending_cmds.size() != 0 || expected_res.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("ran %0d results: full/empty heaps, duplicate, absent,", results_seen);
        $display("key-increase, unused opcode and tie cases");
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
